// ===== sv/sdft_pkg.sv =====
// Shared constants, types and tables for the sliding DFT bin tracker.
package sdft_pkg;

  localparam int ACC_FRAC     = 4;
  localparam int ATAN_ENTRIES = 24;

  typedef logic signed [15:0] sample_t;
  typedef logic signed [31:0] acc_t;
  typedef logic signed [33:0] angle_t;

  localparam logic [1:0] REG_WINDOW = 2'd0;
  localparam logic [1:0] REG_COS    = 2'd1;
  localparam logic [1:0] REG_SIN    = 2'd2;

  // arctan(2^-i) with pi = 2^31
  function automatic angle_t atan_unit(input logic [4:0] idx);
    angle_t v;
    begin
      case (idx)
        5'd0:  v = 34'sh020000000;
        5'd1:  v = 34'sh012E4051E;
        5'd2:  v = 34'sh009FB385B;
        5'd3:  v = 34'sh0051111D4;
        5'd4:  v = 34'sh0028B0D43;
        5'd5:  v = 34'sh00145D7E1;
        5'd6:  v = 34'sh000A2F61E;
        5'd7:  v = 34'sh000517C55;
        5'd8:  v = 34'sh00028BE53;
        5'd9:  v = 34'sh000145F2F;
        5'd10: v = 34'sh0000A2F98;
        5'd11: v = 34'sh0000517CC;
        5'd12: v = 34'sh000028BE6;
        5'd13: v = 34'sh0000145F3;
        5'd14: v = 34'sh00000A2FA;
        5'd15: v = 34'sh00000517D;
        5'd16: v = 34'sh0000028BE;
        5'd17: v = 34'sh00000145F;
        5'd18: v = 34'sh000000A30;
        5'd19: v = 34'sh000000518;
        5'd20: v = 34'sh00000028C;
        5'd21: v = 34'sh000000146;
        5'd22: v = 34'sh0000000A3;
        5'd23: v = 34'sh000000051;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

  // round by 2^17 (floor of value + 2^16) and saturate to 32 bits
  function automatic acc_t round_sat(input logic signed [52:0] m);
    logic signed [52:0] t;
    begin
      t = (m + 53'sd65536) >>> 17;
      if (t > 53'sd2147483647)
        return 32'sh7FFFFFFF;
      else if (t < -53'sd2147483648)
        return 32'sh80000000;
      else
        return t[31:0];
    end
  endfunction

endpackage

// ===== sv/sliding_dft_bin_tracker_core.sv =====
// Sliding single-bin DFT tracker: sample ring, twiddle rotation, magnitude and phase.
//
//  channel  direction  signals                        moves
//  in       input      in_valid/in_stall, in_sample   one sample per request
//  out      output     out_valid/out_stall, amplitude, phase  one result per request
//  cfg      input      cfg_we, cfg_index, cfg_data    register write
//
// Each sample passes in order through the ring read, the four shared multiplies and the
// two squares, the bit-serial square root (CORDIC runs alongside it), the amplitude
// division and the load of the output register; the next request is taken only once
// the output register has been loaded, and a stalled output keeps the block in S_DONE.
// A finished result waits in the output register while the next sample is taken.
// After reset and after any window write the ring is cleared one entry a cycle
// with in_stall high.
module sliding_dft_bin_tracker_core #(
  parameter int MAX_WINDOW   = 256,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  sdft_pkg::sample_t       in_sample,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [15:0]             out_amplitude,
  output logic signed [15:0]      out_phase,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [17:0]             cfg_data
);
  import sdft_pkg::*;

  localparam int AW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int NW   = $clog2(MAX_WINDOW + 1);
  localparam int CW   = (NW > 9) ? NW : 9;
  localparam int DENW = NW + ACC_FRAC;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_READ = 4'd1;
  localparam logic [3:0] S_DIFF = 4'd2;
  localparam logic [3:0] S_MUL0 = 4'd3;
  localparam logic [3:0] S_MUL1 = 4'd4;
  localparam logic [3:0] S_MUL2 = 4'd5;
  localparam logic [3:0] S_MUL3 = 4'd6;
  localparam logic [3:0] S_MUL4 = 4'd7;
  localparam logic [3:0] S_SQ0  = 4'd8;
  localparam logic [3:0] S_SQ1  = 4'd9;
  localparam logic [3:0] S_ROOT = 4'd10;
  localparam logic [3:0] S_DCHK = 4'd11;
  localparam logic [3:0] S_DIV  = 4'd12;
  localparam logic [3:0] S_DONE = 4'd13;

  logic [3:0]          state_r;
  logic [8:0]          win_len_r;
  logic signed [17:0]  rot_cos_r, rot_sin_r;
  logic                clr_busy_r;
  logic [AW-1:0]       clr_addr_r, wr_idx_r;
  sample_t             sample_r, rd_data_r;
  logic signed [32:0]  re_r;
  acc_t                real_r, imag_r, real_new_r;
  logic signed [52:0]  macc_r;
  logic [63:0]         sq_r, v_r, root_r, bit_r;
  logic [4:0]          rcnt_r;
  logic [33:0]         num_r;
  logic [DENW-1:0]     rem_r;
  logic [15:0]         q_r;
  logic [3:0]          dcnt_r;
  logic                out_valid_r;
  logic [15:0]         amp_r;
  logic signed [15:0]  phase_r;

  sample_t             ring [MAX_WINDOW];

  // effective window, clamped to [2, MAX_WINDOW]
  logic [CW-1:0]       wl_ext;
  logic [NW-1:0]       n_eff;
  logic [DENW-1:0]     den;
  always_comb begin
    wl_ext = CW'(win_len_r);
    if (wl_ext < CW'(2))
      n_eff = NW'(2);
    else if (wl_ext > CW'(MAX_WINDOW))
      n_eff = NW'(MAX_WINDOW);
    else
      n_eff = NW'(wl_ext);
  end
  assign den = {n_eff, {ACC_FRAC{1'b0}}};

  logic in_acc, win_wr;
  assign in_stall = clr_busy_r || (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign win_wr   = cfg_we && (cfg_index == REG_WINDOW);

  // ring memory
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  sample_t         mem_wdata;
  assign mem_we    = clr_busy_r || (state_r == S_DIFF);
  assign mem_waddr = clr_busy_r ? clr_addr_r : wr_idx_r;
  assign mem_wdata = clr_busy_r ? sample_t'(0) : sample_r;

  always_ff @(posedge clk) begin
    if (mem_we)
      ring[mem_waddr] <= mem_wdata;
    rd_data_r <= ring[wr_idx_r];
  end

  // shared rotation multiplier
  logic signed [17:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [50:0] mul_p;
  always_comb begin
    case (state_r)
      S_MUL0:  begin mul_a = rot_cos_r; mul_b = re_r;          end
      S_MUL1:  begin mul_a = rot_sin_r; mul_b = 33'(imag_r);   end
      S_MUL2:  begin mul_a = rot_sin_r; mul_b = re_r;          end
      default: begin mul_a = rot_cos_r; mul_b = 33'(imag_r);   end
    endcase
  end
  assign mul_p = 51'(mul_a) * 51'(mul_b);

  // squaring multiplier
  acc_t               sq_in;
  logic signed [63:0] sq_p;
  assign sq_in = (state_r == S_SQ0) ? real_r : imag_r;
  assign sq_p  = 64'(sq_in) * 64'(sq_in);

  logic signed [16:0] diff;
  assign diff = 17'(sample_r) - 17'(rd_data_r);

  // square root step
  logic [63:0] rtrial;
  assign rtrial = root_r + bit_r;

  // amplitude numerator and division step
  logic [33:0]     num;
  logic [DENW:0]   dtrial;
  assign num    = {root_r[31:0], 1'b0} + 34'(den >> 1);
  assign dtrial = {rem_r, num_r[15]};

  // CORDIC
  logic   cor_start, cor_done;
  angle_t cor_z;
  logic signed [33:0] ph_full;
  assign cor_start = (state_r == S_SQ0);
  assign ph_full   = (cor_z + 34'sd32768) >>> 16;

  sdft_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .x_in  (real_r),
    .y_in  (imag_r),
    .done  (cor_done),
    .z_out (cor_z)
  );

  logic out_load;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      win_len_r   <= 9'd256;
      rot_cos_r   <= 18'sd131033;
      rot_sin_r   <= 18'sd3217;
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      wr_idx_r    <= '0;
      real_r      <= '0;
      imag_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WINDOW: win_len_r <= cfg_data[8:0];
          REG_COS:    rot_cos_r <= cfg_data;
          REG_SIN:    rot_sin_r <= cfg_data;
          default: ;
        endcase
      end

      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(MAX_WINDOW - 1))
          clr_busy_r <= 1'b0;
      end

      if (out_valid_r && !out_stall)
        out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: if (in_acc) state_r <= S_READ;
        S_READ: state_r <= S_DIFF;
        S_DIFF: begin
          if (NW'(wr_idx_r) == n_eff - 1'b1)
            wr_idx_r <= '0;
          else
            wr_idx_r <= wr_idx_r + 1'b1;
          state_r <= S_MUL0;
        end
        S_MUL0: state_r <= S_MUL1;
        S_MUL1: state_r <= S_MUL2;
        S_MUL2: state_r <= S_MUL3;
        S_MUL3: state_r <= S_MUL4;
        S_MUL4: begin
          real_r  <= real_new_r;
          imag_r  <= round_sat(macc_r);
          state_r <= S_SQ0;
        end
        S_SQ0:  state_r <= S_SQ1;
        S_SQ1:  state_r <= S_ROOT;
        S_ROOT: if (rcnt_r == 5'd31) state_r <= S_DCHK;
        S_DCHK: state_r <= (64'(num) >= (64'(den) << 16)) ? S_DONE : S_DIV;
        S_DIV:  if (dcnt_r == 4'd15) state_r <= S_DONE;
        S_DONE: if (out_load) begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b1;
        end
        default: state_r <= S_IDLE;
      endcase

      if (win_wr) begin
        clr_busy_r <= 1'b1;
        clr_addr_r <= '0;
        wr_idx_r   <= '0;
        real_r     <= '0;
        imag_r     <= '0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc)
      sample_r <= in_sample;
    case (state_r)
      S_DIFF: re_r <= 33'(real_r) + (33'(diff) <<< ACC_FRAC);
      S_MUL0: macc_r <= 53'(mul_p);
      S_MUL1: macc_r <= macc_r - 53'(mul_p);
      S_MUL2: begin
        real_new_r <= round_sat(macc_r);
        macc_r     <= 53'(mul_p);
      end
      S_MUL3: macc_r <= macc_r + 53'(mul_p);
      S_SQ0:  sq_r <= sq_p;
      S_SQ1: begin
        v_r    <= sq_r + sq_p;
        root_r <= '0;
        bit_r  <= 64'h4000_0000_0000_0000;
        rcnt_r <= '0;
      end
      S_ROOT: begin
        if (v_r >= rtrial) begin
          v_r    <= v_r - rtrial;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r  <= bit_r >> 2;
        rcnt_r <= rcnt_r + 1'b1;
      end
      S_DCHK: begin
        num_r  <= num;
        rem_r  <= DENW'(num >> 16);
        q_r    <= 16'hFFFF;
        dcnt_r <= '0;
      end
      S_DIV: begin
        if (dtrial >= (DENW+1)'(den)) begin
          rem_r <= DENW'(dtrial - (DENW+1)'(den));
          q_r   <= {q_r[14:0], 1'b1};
        end else begin
          rem_r <= DENW'(dtrial);
          q_r   <= {q_r[14:0], 1'b0};
        end
        num_r  <= {num_r[32:0], 1'b0};
        dcnt_r <= dcnt_r + 1'b1;
      end
      default: ;
    endcase
    if (out_load) begin
      amp_r   <= q_r;
      phase_r <= (real_r == 0 && imag_r == 0) ? 16'sd0 : ph_full[15:0];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_amplitude = amp_r;
  assign out_phase     = phase_r;

`ifndef SYNTHESIS
  a_idx_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    NW'(wr_idx_r) < n_eff)
    else $error("ring index beyond window");

  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !win_wr |=> state_r == S_READ)
    else $error("accepted request did not start a ring read");

  a_cordic_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DCHK |-> cor_done)
    else $error("CORDIC still running at division");
`endif

endmodule

// ===== sv/sdft_cordic.sv =====
// Iterative CORDIC in vectoring mode: angle of (x, y), pi = 2^31.
module sdft_cordic #(
  parameter int STEPS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  sdft_pkg::acc_t  x_in,
  input  sdft_pkg::acc_t  y_in,
  output logic            done,
  output sdft_pkg::angle_t z_out
);
  import sdft_pkg::*;

  localparam int NSTEP = (STEPS < ATAN_ENTRIES) ? STEPS : ATAN_ENTRIES;
  localparam int IW    = $clog2(NSTEP + 1);

  logic signed [35:0] x_r, y_r, dx, dy, xe, ye;
  angle_t             z_r, at;
  logic [IW-1:0]      i_r;
  logic               run_r;

  assign xe = 36'(x_in);
  assign ye = 36'(y_in);
  assign dx = y_r >>> i_r;
  assign dy = x_r >>> i_r;
  assign at = atan_unit(5'(i_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      i_r   <= '0;
    end else if (start) begin
      run_r <= 1'b1;
      i_r   <= '0;
    end else if (run_r) begin
      i_r <= i_r + 1'b1;
      if (i_r == IW'(NSTEP - 1))
        run_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // quarter-turn pre-rotation for the left half-plane
      if (xe < 0) begin
        if (ye >= 0) begin
          x_r <= ye;
          y_r <= -xe;
          z_r <= 34'sh040000000;
        end else begin
          x_r <= -ye;
          y_r <= xe;
          z_r <= -34'sh040000000;
        end
      end else begin
        x_r <= xe;
        y_r <= ye;
        z_r <= '0;
      end
    end else if (run_r) begin
      if (y_r > 0) begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at;
      end else begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at;
      end
    end
  end

  assign done  = !run_r;
  assign z_out = z_r;

endmodule
